FILE: rtl/tac_pkg.sv
// Shared types, constants and register codes for the touch averaging and
// calibration block. No dependencies.
package tac_pkg;

    localparam int SAMPLES_DEF     = 5;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam logic [15:0] CAL_X_LOW_RST     = 16'd0;
    localparam logic [15:0] CAL_X_HIGH_RST    = 16'd4095;
    localparam logic [15:0] CAL_Y_LOW_RST     = 16'd0;
    localparam logic [15:0] CAL_Y_HIGH_RST    = 16'd4095;
    localparam logic [15:0] SCREEN_X_MAX_RST  = 16'd239;
    localparam logic [15:0] SCREEN_Y_MAX_RST  = 16'd319;
    localparam logic [12:0] PRESS_FLOOR_RST   = 13'd100;
    localparam logic [12:0] PRESS_CEILING_RST = 13'd4000;

    typedef enum logic [2:0] {
        REG_CAL_X_LOW     = 3'd0,
        REG_CAL_X_HIGH    = 3'd1,
        REG_CAL_Y_LOW     = 3'd2,
        REG_CAL_Y_HIGH    = 3'd3,
        REG_SCREEN_X_MAX  = 3'd4,
        REG_SCREEN_Y_MAX  = 3'd5,
        REG_PRESS_FLOOR   = 3'd6,
        REG_PRESS_CEILING = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] word_x;
        logic [15:0] word_y;
    } in_item_t;

    typedef struct packed {
        logic [12:0] avg_x;
        logic [12:0] avg_y;
        logic        pressed;
        logic [15:0] screen_x;
        logic [15:0] screen_y;
    } out_item_t;

    typedef struct packed {
        logic [15:0] cal_x_low;
        logic [15:0] cal_x_high;
        logic [15:0] cal_y_low;
        logic [15:0] cal_y_high;
        logic [15:0] screen_x_max;
        logic [15:0] screen_y_max;
        logic [12:0] press_floor;
        logic [12:0] press_ceiling;
    } cfg_t;

    typedef struct packed {
        logic [15:0] sum_x;
        logic [15:0] sum_y;
    } grp_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PREP,
        BK_MUL_X,
        BK_GO_X,
        BK_DIV_X,
        BK_MUL_Y,
        BK_GO_Y,
        BK_DIV_Y,
        BK_EMIT
    } back_state_t;

endpackage

FILE: rtl/touch_average_and_calibrate_top.sv
// Top level of the touch averaging and calibration block: configuration
// registers, front end, group queue and back end. Depends on tac_pkg and all tac_* modules.
//
// s_valid/s_ready/s_data carry one X and one Y converter word per transaction;
// the sample is bits 15..3 of each word. The front end takes one transaction
// per cycle while the group queue has room. After every SAMPLES input
// transactions one result leaves on m_valid/m_ready/m_data: both averages, the
// pressed flag and the mapped screen coordinates (zero when not pressed).
// cfg_valid/cfg_ready/cfg_index/cfg_data write the calibration registers;
// cfg_ready is always high. Write only while the block is idle.
// After the last transaction of a group, the back end pops the group, then forms
// the averages and the press check; when pressed, it makes two 32-step passes
// through the shared divider, and an axis with zero span skips its pass. The
// back end takes the next group from the queue only after it has passed the
// current result to the output register. Reset clears sums, counters, the queue
// and the output valid flag, and loads the default calibration. When the
// receiver stalls, the result holds in the output register, the back end waits
// with its next result, and the front end keeps accepting until the queue is
// full.
module touch_average_and_calibrate_top #(
    parameter int SAMPLES     = tac_pkg::SAMPLES_DEF,
    parameter int QUEUE_DEPTH = tac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tac_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tac_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    tac_pkg::cfg_t cfg_reg, cfg_next;
    tac_pkg::grp_t push_data, pop_data;
    logic          q_push, q_pop, q_full, q_empty;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (tac_pkg::cfg_idx_t'(cfg_index))
                tac_pkg::REG_CAL_X_LOW:     cfg_next.cal_x_low     = cfg_data;
                tac_pkg::REG_CAL_X_HIGH:    cfg_next.cal_x_high    = cfg_data;
                tac_pkg::REG_CAL_Y_LOW:     cfg_next.cal_y_low     = cfg_data;
                tac_pkg::REG_CAL_Y_HIGH:    cfg_next.cal_y_high    = cfg_data;
                tac_pkg::REG_SCREEN_X_MAX:  cfg_next.screen_x_max  = cfg_data;
                tac_pkg::REG_SCREEN_Y_MAX:  cfg_next.screen_y_max  = cfg_data;
                tac_pkg::REG_PRESS_FLOOR:   cfg_next.press_floor   = cfg_data[12:0];
                tac_pkg::REG_PRESS_CEILING: cfg_next.press_ceiling = cfg_data[12:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_x_low     <= tac_pkg::CAL_X_LOW_RST;
            cfg_reg.cal_x_high    <= tac_pkg::CAL_X_HIGH_RST;
            cfg_reg.cal_y_low     <= tac_pkg::CAL_Y_LOW_RST;
            cfg_reg.cal_y_high    <= tac_pkg::CAL_Y_HIGH_RST;
            cfg_reg.screen_x_max  <= tac_pkg::SCREEN_X_MAX_RST;
            cfg_reg.screen_y_max  <= tac_pkg::SCREEN_Y_MAX_RST;
            cfg_reg.press_floor   <= tac_pkg::PRESS_FLOOR_RST;
            cfg_reg.press_ceiling <= tac_pkg::PRESS_CEILING_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tac_front #(
        .SAMPLES (SAMPLES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (push_data)
    );

    tac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    tac_back #(
        .SAMPLES (SAMPLES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/tac_front.sv
// Front end: accepts input transactions and accumulates per-axis sums.
// Pushes a finished group to the queue. Depends on tac_pkg.
module tac_front #(
    parameter int SAMPLES = tac_pkg::SAMPLES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tac_pkg::in_item_t s_data,
    input  logic             q_full,
    output logic             q_push,
    output tac_pkg::grp_t    q_data
);

    localparam int CNT_W = $clog2(SAMPLES + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      sum_x_reg, sum_x_next;
    logic [15:0]      sum_y_reg, sum_y_next;
    logic [15:0]      add_x, add_y;
    logic             accept, last;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign last    = (cnt_reg == CNT_W'(SAMPLES - 1));
    assign add_x   = sum_x_reg + {3'b000, s_data.word_x[15:3]};
    assign add_y   = sum_y_reg + {3'b000, s_data.word_y[15:3]};

    assign q_push       = accept && last;
    assign q_data.sum_x = add_x;
    assign q_data.sum_y = add_y;

    always_comb begin
        cnt_next   = cnt_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (accept) begin
            if (last) begin
                cnt_next   = '0;
                sum_x_next = '0;
                sum_y_next = '0;
            end else begin
                cnt_next   = cnt_reg + 1'b1;
                sum_x_next = add_x;
                sum_y_next = add_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end else begin
            cnt_reg   <= cnt_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

endmodule

FILE: rtl/tac_queue.sv
// Short FIFO of finished sum groups between front and back end.
// Depends on tac_pkg.
module tac_queue #(
    parameter int DEPTH = tac_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  tac_pkg::grp_t push_data,
    output logic          full,
    input  logic          pop,
    output tac_pkg::grp_t pop_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tac_pkg::grp_t    mem [DEPTH];
    tac_pkg::grp_t    head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CNT_W'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = head_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // head entry registered; bypass when the write lands on the next head
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (push && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= push_data;
        end else begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: rtl/tac_div.sv
// Shared restoring divider, one quotient bit per cycle, 32 steps.
// Depends on tac_pkg.
module tac_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  tac_pkg::div_req_t req,
    output tac_pkg::div_rsp_t rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [tac_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]                   rem_reg, rem_next;
    logic [31:0]                   quo_reg, quo_next;
    logic [15:0]                   dsr_reg, dsr_next;
    logic [16:0]                   part, diff;

    assign part = {rem_reg, quo_reg[31]};
    assign diff = part - {1'b0, dsr_reg};

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[15:0];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = req.divisor;
            quo_next  = req.dividend;
            cnt_next  = tac_pkg::DIV_CNT_W'(tac_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            cnt_next = cnt_reg - 1'b1;
            if (!diff[16]) begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = part[15:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            if (cnt_reg == tac_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

FILE: rtl/tac_back.sv
// Back end: averages by reciprocal multiply, press check, clamp and linear scaling
// of one group. Sequencer around tac_div and two 16x16 multiplies. Depends on tac_pkg, tac_div.
module tac_back #(
    parameter int SAMPLES = tac_pkg::SAMPLES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tac_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  tac_pkg::grp_t      q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output tac_pkg::out_item_t m_data
);

    // sum / SAMPLES exact while sum * AVG_RECIP fits in 32 bits, which holds for 5 samples of 13 bits
    localparam int          AVG_SHIFT = 19;
    localparam logic [19:0] AVG_RECIP = 20'(((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

    typedef struct packed {
        logic [15:0] num;
        logic [15:0] span;
    } axis_t;

    function automatic axis_t prep_axis(logic [15:0] v, logic [15:0] from,
                                        logic [15:0] to);
        axis_t       r;
        logic [15:0] c;
        if (from < to) begin
            c      = (v < from) ? from : ((v > to) ? to : v);
            r.num  = c - from;
            r.span = to - from;
        end else begin
            c      = (v > from) ? from : ((v < to) ? to : v);
            r.num  = from - c;
            r.span = from - to;
        end
        return r;
    endfunction

    tac_pkg::back_state_t state_reg, state_next;
    tac_pkg::div_req_t    div_req;
    tac_pkg::div_rsp_t    div_rsp;
    tac_pkg::out_item_t   m_data_reg, m_data_next;
    logic                 m_valid_reg, m_valid_next;
    logic [31:0]          avg_px, avg_py;
    logic [12:0]          avg_x_reg, avg_x_next;
    logic [12:0]          avg_y_reg, avg_y_next;
    logic                 pressed_reg, pressed_next;
    axis_t                ax_reg, ax_next;
    axis_t                ay_reg, ay_next;
    logic [31:0]          prod_reg, prod_next;
    logic [15:0]          scr_x_reg, scr_x_next;
    logic [15:0]          scr_y_reg, scr_y_next;

    tac_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign avg_px = 32'(q_data.sum_x) * 32'(AVG_RECIP);
    assign avg_py = 32'(q_data.sum_y) * 32'(AVG_RECIP);

    always_comb begin
        state_next       = state_reg;
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = ax_reg.span;
        avg_x_next       = avg_x_reg;
        avg_y_next       = avg_y_reg;
        pressed_next     = pressed_reg;
        ax_next          = ax_reg;
        ay_next          = ay_reg;
        prod_next        = prod_reg;
        scr_x_next       = scr_x_reg;
        scr_y_next       = scr_y_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        unique case (state_reg)
            tac_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    avg_x_next = avg_px[AVG_SHIFT +: 13];
                    avg_y_next = avg_py[AVG_SHIFT +: 13];
                    state_next = tac_pkg::BK_PREP;
                end
            end
            tac_pkg::BK_PREP: begin
                pressed_next = (avg_x_reg >= cfg.press_floor) &&
                               (avg_x_reg <= cfg.press_ceiling) &&
                               (avg_y_reg >= cfg.press_floor) &&
                               (avg_y_reg <= cfg.press_ceiling);
                ax_next      = prep_axis({3'b000, avg_x_reg}, cfg.cal_x_high, cfg.cal_x_low);
                ay_next      = prep_axis({3'b000, avg_y_reg}, cfg.cal_y_low, cfg.cal_y_high);
                scr_x_next   = '0;
                scr_y_next   = '0;
                state_next   = pressed_next ? tac_pkg::BK_MUL_X : tac_pkg::BK_EMIT;
            end
            tac_pkg::BK_MUL_X: begin
                prod_next  = {16'h0000, ax_reg.num} * {16'h0000, cfg.screen_x_max};
                state_next = (ax_reg.span != '0) ? tac_pkg::BK_GO_X : tac_pkg::BK_MUL_Y;
            end
            tac_pkg::BK_GO_X: begin
                div_req.start = 1'b1;
                state_next    = tac_pkg::BK_DIV_X;
            end
            tac_pkg::BK_DIV_X: begin
                if (div_rsp.done) begin
                    scr_x_next = div_rsp.quotient;
                    state_next = tac_pkg::BK_MUL_Y;
                end
            end
            tac_pkg::BK_MUL_Y: begin
                prod_next  = {16'h0000, ay_reg.num} * {16'h0000, cfg.screen_y_max};
                state_next = (ay_reg.span != '0) ? tac_pkg::BK_GO_Y : tac_pkg::BK_EMIT;
            end
            tac_pkg::BK_GO_Y: begin
                div_req.start   = 1'b1;
                div_req.divisor = ay_reg.span;
                state_next      = tac_pkg::BK_DIV_Y;
            end
            tac_pkg::BK_DIV_Y: begin
                if (div_rsp.done) begin
                    scr_y_next = div_rsp.quotient;
                    state_next = tac_pkg::BK_EMIT;
                end
            end
            tac_pkg::BK_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next         = 1'b1;
                    m_data_next.avg_x    = avg_x_reg;
                    m_data_next.avg_y    = avg_y_reg;
                    m_data_next.pressed  = pressed_reg;
                    m_data_next.screen_x = scr_x_reg;
                    m_data_next.screen_y = scr_y_reg;
                    state_next           = tac_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = tac_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tac_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_x_reg   <= avg_x_next;
        avg_y_reg   <= avg_y_next;
        pressed_reg <= pressed_next;
        ax_reg      <= ax_next;
        ay_reg      <= ay_next;
        prod_reg    <= prod_next;
        scr_x_reg   <= scr_x_next;
        scr_y_reg   <= scr_y_next;
        m_data_reg  <= m_data_next;
    end

`ifndef SYNTHESIS
    a_unpressed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.pressed) |->
        (m_data_reg.screen_x == 16'h0000 && m_data_reg.screen_y == 16'h0000))
        else $error("unpressed result carries nonzero screen coordinates");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (div_req.divisor != 16'h0000))
        else $error("divider started with zero divisor");
`endif

endmodule
